/* rtl/pfx_pkg.sv */
`default_nettype none

package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int LIMIT_W     = 5;
    localparam int LIM_CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int ITER_W      = $clog2(DATA_W);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DEPTH_LIMIT = '0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 5'd10;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_MISSING  = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_BADTOKEN = 3'd4,
        ST_LEFTOVER = 3'd5
    } pfx_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_LAST_RD,
        S_FINISH
    } pfx_state_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [PTR_W-1:0]  raddr_a;
        logic [PTR_W-1:0]  raddr_b;
    } pfx_stack_req_t;

endpackage

`default_nettype wire

/* rtl/pfx_stack.sv */
`default_nettype none

module pfx_stack import pfx_pkg::*; (
    input  wire logic           aclk,
    input  wire pfx_stack_req_t req,
    output logic [DATA_W-1:0]   rdata_a,
    output logic [DATA_W-1:0]   rdata_b
);

    logic [DATA_W-1:0] mem_reg [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
        rdata_a_reg <= mem_reg[req.raddr_a];
        rdata_b_reg <= mem_reg[req.raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

/* rtl/pfx_divider.sv */
`default_nettype none

module pfx_divider import pfx_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            den_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        iter_reg <= iter_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

/* rtl/postfix_expression_evaluator_core.sv */
`default_nettype none

// Postfix evaluator: one ASCII character per transfer on the input stream, tlast on the
// final character of an expression. The operand stack lives in a 16-entry synchronous RAM
// with two read ports and needs no clearing after reset. A space, a digit, or a character
// that raises or follows an error is handled on acceptance; +, - and * read the stack, then
// write back; / reads the stack, waits for the divider that resolves one quotient bit per
// cycle and writes back the quotient, or raises an error when the divisor is zero. After the
// final character the bottom entry is read and the result register loaded, with a wait
// while an earlier result still waits in that register; the next expression is accepted while
// the new result waits for its transfer. depth_limit is written over APB at address 0 and
// should only change between expressions.
module postfix_expression_evaluator_core import pfx_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SYM_W-1:0]   s_tdata,   // [7:0] symbol
    input  wire logic               s_tlast,   // is_last

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DATA_W-1:0]       m_tdata,   // [31:0] value
    output logic [2:0]              m_tuser,   // [2:0] status

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    pfx_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    pfx_status_t       err_reg, err_next;
    logic [SYM_W-1:0]  sym_reg;
    logic              last_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    pfx_status_t       out_status_reg;

    pfx_stack_req_t    req;
    logic [DATA_W-1:0] rd_top;
    logic [DATA_W-1:0] rd_below;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    logic                 s_accept;
    logic                 in_space;
    logic                 in_digit;
    logic                 in_op;
    logic [SYM_W-1:0]     digit_val;
    logic [LIM_CMP_W-1:0] limit_eff;
    logic                 stack_full;
    logic                 too_few;
    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]     cnt_m2;
    logic                 out_free;
    logic                 out_load;
    pfx_status_t          fin_status;
    logic [DATA_W-1:0]    fin_value;
    logic                 cfg_write;

    pfx_stack u_stack (
        .aclk    (aclk),
        .req     (req),
        .rdata_a (rd_top),
        .rdata_b (rd_below)
    );

    pfx_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_below),
        .divisor  (rd_top),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_accept  = s_tvalid && s_tready;
    assign in_space  = (s_tdata == CH_SPACE);
    assign in_digit  = s_tdata inside {[CH_ZERO:CH_NINE]};
    assign in_op     = s_tdata inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    assign digit_val = s_tdata - CH_ZERO;

    assign limit_eff  = (LIM_CMP_W'(limit_reg) > LIM_CMP_W'(STACK_DEPTH))
                      ? LIM_CMP_W'(STACK_DEPTH) : LIM_CMP_W'(limit_reg);
    assign stack_full = (LIM_CMP_W'(count_reg) >= limit_eff);
    assign too_few    = (count_reg < CNT_W'(2));
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign cnt_m2     = count_reg - CNT_W'(2);

    assign out_free   = !out_valid_reg || m_tready;
    assign fin_status = (err_reg != ST_OK) ? err_reg
                      : ((count_reg == CNT_W'(1)) ? ST_OK : ST_LEFTOVER);
    assign fin_value  = (fin_status == ST_OK) ? rd_top : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (err_reg == ST_OK && in_op && !too_few) begin
                        state_next = S_EXEC;
                    end else if (s_tlast) begin
                        state_next = S_LAST_RD;
                    end
                end
            end
            S_EXEC: begin
                if (sym_reg == CH_SLASH && rd_top != '0) begin
                    state_next = S_DIV;
                end else begin
                    state_next = last_reg ? S_LAST_RD : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = last_reg ? S_LAST_RD : S_IDLE;
                end
            end
            S_LAST_RD: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        req.we      = 1'b0;
        req.waddr   = cnt_m2[PTR_W-1:0];
        req.wdata   = '0;
        req.raddr_a = cnt_m1[PTR_W-1:0];
        req.raddr_b = cnt_m2[PTR_W-1:0];
        count_next  = count_reg;
        err_next    = err_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_accept && err_reg == ST_OK) begin
                    if (in_digit) begin
                        if (stack_full) begin
                            err_next = ST_OVERFLOW;
                        end else begin
                            req.we     = 1'b1;
                            req.waddr  = count_reg[PTR_W-1:0];
                            req.wdata  = DATA_W'(digit_val[3:0]);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (in_op) begin
                        if (too_few) begin
                            err_next = ST_MISSING;
                        end
                    end else if (!in_space) begin
                        err_next = ST_BADTOKEN;
                    end
                end
            end
            S_EXEC: begin
                case (sym_reg)
                    CH_PLUS: begin
                        req.we    = 1'b1;
                        req.wdata = rd_below + rd_top;
                    end
                    CH_MINUS: begin
                        req.we    = 1'b1;
                        req.wdata = rd_below - rd_top;
                    end
                    CH_STAR: begin
                        req.we    = 1'b1;
                        req.wdata = DATA_W'(rd_below * rd_top);
                    end
                    default: begin
                        if (rd_top == '0) begin
                            err_next = ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                endcase
                if (req.we) begin
                    count_next = cnt_m1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    req.we     = 1'b1;
                    req.wdata  = div_quotient;
                    count_next = cnt_m1;
                end
            end
            S_LAST_RD: begin
                req.raddr_a = '0;
            end
            S_FINISH: begin
                req.raddr_a = '0;
                if (out_free) begin
                    out_load   = 1'b1;
                    count_next = '0;
                    err_next   = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            if (cfg_write && paddr[PADDR_W-1:2] == REG_DEPTH_LIMIT) begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            sym_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (out_load) begin
            out_value_reg  <= fin_value;
            out_status_reg <= fin_status;
        end
    end

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_DEPTH_LIMIT) ? PDATA_W'(limit_reg) : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_free) |=> (count_reg == '0 && err_reg == ST_OK))
        else $error("expression state not cleared after result");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (rd_top != '0 && !div_busy))
        else $error("divider started with zero divisor or while busy");

    a_no_accept_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_busy || state_reg == S_DIV) |-> !s_tready)
        else $error("input taken during division");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pfx_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 82;
    localparam int IDLE_PCT     = 32;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_last;
    } sym_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        pfx_status_t       status;
    } eval_result_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SYM_W-1:0]   s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DATA_W-1:0]  m_tdata;
    logic [2:0]         m_tuser;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sym_item_t    pending_syms[$];
    eval_result_t expected_results[$];
    logic [SYM_W-1:0] expr_buf[$];

    logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int unsigned       eval_depth   = 0;
    pfx_status_t       eval_err     = ST_OK;
    logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;

    int  n_fail      = 0;
    int  items_added = 0;
    bit  steady      = 1'b0;
    int  hold_req    = 0;
    int  hold_done   = 0;
    int  hold_cnt    = 0;

    postfix_expression_evaluator_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    task automatic evaluate_symbol(input logic [SYM_W-1:0] ch, input logic last);
        int unsigned  lim;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  r;
        logic [31:0]  ma;
        logic [31:0]  mb;
        logic [31:0]  q;
        eval_result_t res;
        lim = (limit_shadow > STACK_DEPTH) ? STACK_DEPTH : limit_shadow;
        if (eval_err == ST_OK && ch != CH_SPACE) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                if (eval_depth >= lim) begin
                    eval_err = ST_OVERFLOW;
                end else begin
                    eval_stack[eval_depth] = {24'd0, ch - CH_ZERO};
                    eval_depth++;
                end
            end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
                if (eval_depth < 2) begin
                    eval_err = ST_MISSING;
                end else begin
                    b = eval_stack[eval_depth - 1];
                    a = eval_stack[eval_depth - 2];
                    r = '0;
                    if (ch == CH_PLUS) begin
                        r = a + b;
                    end else if (ch == CH_MINUS) begin
                        r = a - b;
                    end else if (ch == CH_STAR) begin
                        r = a * b;
                    end else if (b != 0) begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q  = ma / mb;
                        r  = (a[31] ^ b[31]) ? -q : q;
                    end
                    if (ch == CH_SLASH && b == 0) begin
                        eval_err = ST_DIVZERO;
                    end else begin
                        eval_depth--;
                        eval_stack[eval_depth - 1] = r;
                    end
                end
            end else begin
                eval_err = ST_BADTOKEN;
            end
        end
        if (last) begin
            res.value  = '0;
            res.status = eval_err;
            if (eval_err == ST_OK) begin
                if (eval_depth == 1) begin
                    res.value = eval_stack[0];
                end else begin
                    res.status = ST_LEFTOVER;
                end
            end
            expected_results.push_back(res);
            eval_depth = 0;
            eval_err   = ST_OK;
        end
    endtask

    // Input driver: the predictor runs on every accepted transfer.
    always @(posedge aclk) begin
        sym_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                evaluate_symbol(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_syms.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    item = pending_syms.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.symbol;
                    s_tlast  <= item.is_last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure and one long hold-off during the first phase.
    always @(posedge aclk) begin
        eval_result_t exp_res;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: value %0d status %0d", $signed(m_tdata), m_tuser);
                    n_fail++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata !== exp_res.value) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               $signed(exp_res.value), $signed(m_tdata));
                        n_fail++;
                    end
                    if (m_tuser !== exp_res.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_res.status, m_tuser);
                        n_fail++;
                    end
                end
            end
            if (hold_req != hold_done) begin
                hold_done <= hold_done + 1;
                hold_cnt  <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic cfg_read(input logic [LIMIT_W-1:0] exp_val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_DEPTH_LIMIT, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[LIMIT_W-1:0] !== exp_val) begin
            $error("depth_limit mismatch: expected %0d, actual %0d", exp_val, prdata[LIMIT_W-1:0]);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [LIMIT_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEPTH_LIMIT, 2'b00};
        pwdata  <= {{(PDATA_W - LIMIT_W){1'b0}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        limit_shadow = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_read(val);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_syms.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic flush_expr();
        sym_item_t item;
        for (int i = 0; i < expr_buf.size(); i++) begin
            item.symbol  = expr_buf[i];
            item.is_last = (i == expr_buf.size() - 1);
            pending_syms.push_back(item);
        end
        items_added += expr_buf.size();
        expr_buf.delete();
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
        flush_expr();
    endtask

    function automatic logic [SYM_W-1:0] rand_digit();
        return SYM_W'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [SYM_W-1:0] rand_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    task automatic add_wellformed(input int unsigned eff);
        int unsigned n_dig;
        int unsigned pushed;
        int unsigned d;
        n_dig  = $urandom_range(1, 12);
        pushed = 0;
        d      = 0;
        while (pushed < n_dig || d > 1) begin
            if ($urandom_range(0, 99) < 15) expr_buf.push_back(CH_SPACE);
            if (pushed < n_dig && d < eff && (d < 2 || $urandom_range(0, 1) == 1)) begin
                expr_buf.push_back(rand_digit());
                pushed++;
                d++;
            end else if (d >= 2) begin
                expr_buf.push_back(rand_op());
                d--;
            end else begin
                break;
            end
        end
        if (expr_buf.size() == 0) expr_buf.push_back(rand_digit());
    endtask

    task automatic gen_expr(input int unsigned eff);
        int unsigned shape;
        int unsigned n;
        shape = $urandom_range(0, 99);
        if (shape < 8 && eff >= 3) begin
            // Builds the most negative value, then applies it against minus one.
            expr_buf.push_back(SYM_W'(CH_ZERO + 2));
            repeat (10) begin
                expr_buf.push_back(SYM_W'(CH_ZERO + 8));
                expr_buf.push_back(CH_STAR);
            end
            expr_buf.push_back(CH_ZERO);
            expr_buf.push_back(SYM_W'(CH_ZERO + 1));
            expr_buf.push_back(CH_MINUS);
            expr_buf.push_back(($urandom_range(0, 3) != 0) ? CH_SLASH : rand_op());
        end else if (shape < 16) begin
            n = (eff < STACK_DEPTH) ? eff + 1 : STACK_DEPTH + 1;
            repeat (n) expr_buf.push_back(rand_digit());
            repeat ($urandom_range(0, n)) expr_buf.push_back(rand_op());
        end else if (shape < 80) begin
            add_wellformed(eff);
            if (shape >= 70) begin
                expr_buf[$urandom_range(0, expr_buf.size() - 1)] = SYM_W'($urandom_range(0, 255));
            end
        end else begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0, 1: expr_buf.push_back(SYM_W'($urandom_range(0, 255)));
                    2: expr_buf.push_back(rand_digit());
                    default: expr_buf.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : rand_op());
                endcase
            end
        end
        if ($urandom_range(0, 9) == 0) expr_buf.push_back(CH_SPACE);
        flush_expr();
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_lim [8];
        int unsigned eff;
        int phase_end;
        phase_lim = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd10, 5'd0, 5'd0};
        phase_lim[6] = LIMIT_W'($urandom_range(3, 15));
        phase_lim[7] = LIMIT_W'($urandom_range(0, 31));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        cfg_read(LIMIT_RESET);

        send_str("93-4*2/1+");
        send_str("+");
        send_str("50/");
        send_str("12");
        send_str(" ");
        send_str("7 ");
        send_str("07-2/");
        expr_buf.push_back(8'hFF);
        flush_expr();
        expr_buf.push_back(8'h80);
        send_str("12+");
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            cfg_write(phase_lim[p]);
            eff = (phase_lim[p] > STACK_DEPTH) ? STACK_DEPTH : phase_lim[p];
            steady = (p == 3);
            phase_end = items_added + PHASE_ITEMS;
            while (items_added < phase_end) gen_expr(eff);
            if (p == 0) hold_req++;
            wait_idle();
            steady = 1'b0;
        end

        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pfx_pkg.sv
rtl/pfx_stack.sv
rtl/pfx_divider.sv
rtl/postfix_expression_evaluator_core.sv
dv/tb_top.sv
